/* src/red_pkg.sv */
// Shared types and constants for the rotary encoder and button decoder.
`default_nettype none
package red_pkg;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned CFG_INDEX_W = 2;

    typedef logic [TIME_W-1:0] time_t;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ROTATE_DEBOUNCE_US = 2'd0,
        CFG_SWITCH_DEBOUNCE_MS = 2'd1,
        CFG_ROTATE_GUARD_US    = 2'd2,
        CFG_HOLD_MS            = 2'd3
    } cfg_reg_t;

    localparam time_t ROTATE_DEBOUNCE_US_RST = 32'd1000;
    localparam time_t SWITCH_DEBOUNCE_MS_RST = 32'd50;
    localparam time_t ROTATE_GUARD_US_RST    = 32'd100000;
    localparam time_t HOLD_MS_RST            = 32'd500;

    typedef enum logic [2:0] {
        EV_NONE  = 3'd0,
        EV_CW    = 3'd1,
        EV_CCW   = 3'd2,
        EV_PRESS = 3'd3,
        EV_HOLD  = 3'd4
    } event_t;

    typedef struct packed {
        logic  clk_level;
        logic  dt_level;
        logic  switch_level;
        time_t now_us;
        time_t now_ms;
    } sample_t;

    typedef struct packed {
        time_t rotate_debounce_us;
        time_t switch_debounce_ms;
        time_t rotate_guard_us;
        time_t hold_ms;
    } cfg_t;

endpackage
`default_nettype wire

/* src/rotary_encoder_button_decoder_unit.sv */
// Top level of the rotary encoder and button decoder: input and result registers.
// A sample is held in the sample register, its event in the result register.
// Throughput: one sample per cycle while out_ready does not stall the output;
// the decode state is updated when a sample is decoded, so the next one sees it.
// Reset clears both valid flags, loads the decode state and the configuration
// registers with their reset values; the block is ready in the first cycle after.
`default_nettype none
module rotary_encoder_button_decoder_unit
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic                clk_level,
    input  wire logic                dt_level,
    input  wire logic                switch_level,
    input  wire red_pkg::time_t      now_us,
    input  wire red_pkg::time_t      now_ms,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [2:0]               event_code,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire red_pkg::cfg_index_t cfg_index,
    input  wire red_pkg::time_t      cfg_data
);
    import red_pkg::*;

    logic    s1_valid_reg;
    logic    s1_valid_next;
    sample_t sample_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    event_t  event_reg;
    event_t  core_ev;
    cfg_t    cfg;
    logic    advance;
    logic    in_fire;
    logic    core_fire;

    assign advance   = !out_valid_reg || out_ready;
    assign in_ready  = !s1_valid_reg || advance;
    assign in_fire   = in_valid && in_ready;
    assign core_fire = s1_valid_reg && advance;
    assign cfg_ready = 1'b1;

    red_cfg_regs u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    red_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (core_fire),
        .sample (sample_reg),
        .cfg    (cfg),
        .ev     (core_ev)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = advance ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            sample_reg.clk_level    <= clk_level;
            sample_reg.dt_level     <= dt_level;
            sample_reg.switch_level <= switch_level;
            sample_reg.now_us       <= now_us;
            sample_reg.now_ms       <= now_ms;
        end
        if (core_fire)
        begin
            event_reg <= core_ev;
        end
    end

    assign out_valid  = out_valid_reg;
    assign event_code = 3'(event_reg);

    a_result_follows_decode: assert property (@(posedge clk) disable iff (!rst_n)
        core_fire |=> out_valid_reg)
        else $error("Decoded sample did not reach the result register.");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> !(s1_valid_reg && !advance))
        else $error("Sample register overwritten while stalled.");

    a_event_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> event_code <= 3'(EV_HOLD))
        else $error("Result beat carries an undefined event code.");

endmodule
`default_nettype wire

/* src/red_cfg_regs.sv */
// Configuration register file for the rotary encoder and button decoder.
`default_nettype none
module red_cfg_regs
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_en,
    input  wire red_pkg::cfg_index_t wr_index,
    input  wire red_pkg::time_t    wr_data,
    output red_pkg::cfg_t          cfg
);
    import red_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (cfg_reg_t'(wr_index))
                CFG_ROTATE_DEBOUNCE_US: cfg_next.rotate_debounce_us = wr_data;
                CFG_SWITCH_DEBOUNCE_MS: cfg_next.switch_debounce_ms = wr_data;
                CFG_ROTATE_GUARD_US:    cfg_next.rotate_guard_us    = wr_data;
                CFG_HOLD_MS:            cfg_next.hold_ms            = wr_data;
                default:                cfg_next                    = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rotate_debounce_us <= ROTATE_DEBOUNCE_US_RST;
            cfg_reg.switch_debounce_ms <= SWITCH_DEBOUNCE_MS_RST;
            cfg_reg.rotate_guard_us    <= ROTATE_GUARD_US_RST;
            cfg_reg.hold_ms            <= HOLD_MS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

/* src/red_core.sv */
// Decode state and combinational event logic for one registered sample.
`default_nettype none
module red_core
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             fire,
    input  wire red_pkg::sample_t sample,
    input  wire red_pkg::cfg_t    cfg,
    output red_pkg::event_t       ev
);
    import red_pkg::*;

    logic  prev_clk_reg;
    logic  prev_clk_next;
    logic  prev_switch_reg;
    logic  prev_switch_next;
    time_t rot_time_reg;
    time_t rot_time_next;
    time_t sw_time_reg;
    time_t sw_time_next;
    logic  switch_down_reg;
    logic  switch_down_next;
    logic  hold_reported_reg;
    logic  hold_reported_next;
    time_t us_since_rot;
    time_t ms_since_sw;
    event_t ev_comb;

    assign us_since_rot = sample.now_us - rot_time_reg;
    assign ms_since_sw  = sample.now_ms - sw_time_reg;

    always_comb
    begin
        prev_clk_next      = sample.clk_level;
        prev_switch_next   = prev_switch_reg;
        rot_time_next      = rot_time_reg;
        sw_time_next       = sw_time_reg;
        switch_down_next   = switch_down_reg;
        hold_reported_next = hold_reported_reg;
        ev_comb            = EV_NONE;
        if ((sample.clk_level != prev_clk_reg) && (us_since_rot > cfg.rotate_debounce_us))
        begin
            rot_time_next = sample.now_us;
            ev_comb = (sample.dt_level != sample.clk_level) ? EV_CW : EV_CCW;
        end
        else if (sample.switch_level != prev_switch_reg)
        begin
            if (ms_since_sw > cfg.switch_debounce_ms)
            begin
                prev_switch_next = sample.switch_level;
                sw_time_next     = sample.now_ms;
                if (us_since_rot > cfg.rotate_guard_us)
                begin
                    if (!sample.switch_level)
                    begin
                        switch_down_next   = 1'b1;
                        hold_reported_next = 1'b0;
                    end
                    else
                    begin
                        if (switch_down_reg && !hold_reported_reg)
                        begin
                            ev_comb = EV_PRESS;
                        end
                        switch_down_next = 1'b0;
                    end
                end
                else
                begin
                    switch_down_next = 1'b0;
                end
            end
        end
        else if (switch_down_reg && !sample.switch_level && !hold_reported_reg)
        begin
            if (ms_since_sw > cfg.hold_ms)
            begin
                hold_reported_next = 1'b1;
                ev_comb            = EV_HOLD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_clk_reg      <= 1'b1;
            prev_switch_reg   <= 1'b1;
            rot_time_reg      <= '0;
            sw_time_reg       <= '0;
            switch_down_reg   <= 1'b0;
            hold_reported_reg <= 1'b0;
        end
        else if (fire)
        begin
            prev_clk_reg      <= prev_clk_next;
            prev_switch_reg   <= prev_switch_next;
            rot_time_reg      <= rot_time_next;
            sw_time_reg       <= sw_time_next;
            switch_down_reg   <= switch_down_next;
            hold_reported_reg <= hold_reported_next;
        end
    end

    assign ev = ev_comb;

    a_rotation_needs_clk_change: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (ev_comb == EV_CW || ev_comb == EV_CCW) |-> sample.clk_level != prev_clk_reg)
        else $error("Rotation event without a CLK change.");

    a_hold_once: assert property (@(posedge clk) disable iff (!rst_n)
        fire && ev_comb == EV_HOLD |=> hold_reported_reg && switch_down_reg)
        else $error("Hold event did not mark the hold as reported.");

    a_press_on_release: assert property (@(posedge clk) disable iff (!rst_n)
        fire && ev_comb == EV_PRESS |-> sample.switch_level && switch_down_reg)
        else $error("Press event without a release of a pressed switch.");

endmodule
`default_nettype wire
